// ----- rtl/core/wildcard_pattern_scanner_core_macros.svh -----
// ----------------------------------------------------------------------------
// Wildcard pattern scanner: assertion macros
// Shared forms for the concurrent checks on the scanner ports.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_SCANNER_CORE_MACROS_SVH
`define WILDCARD_PATTERN_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wildcard pattern scanner check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wildcard pattern scanner check failed");

`endif

// ----- rtl/core/wps_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern scanner package
// Sizes, register indexes, resolve modes and the types shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package wps_pkg;

	localparam int MAX_PATTERN  = 16;
	localparam int WINDOW_BYTES = 32;
	localparam int PAT_IDX_W    = $clog2(MAX_PATTERN);
	localparam int WIN_IDX_W    = $clog2(WINDOW_BYTES);
	localparam int CNT_W        = 33;
	localparam int NEED_W       = 6;
	localparam int LEN_W        = 5;
	localparam int OFF_W        = 5;
	localparam int MODE_W       = 2;
	localparam int ADDR_W       = 64;
	localparam int DISP_W       = 32;
	localparam int DISP_BYTES   = DISP_W / 8;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int MASK_W       = 16;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_AW     = 1;
	localparam int QUEUE_CW     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WILD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFF      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd6;

	localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ABS   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REL7  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_JMP5  = 2'd3;

	localparam logic [NEED_W-1:0] DISP_BIAS = 6'd4;
	localparam logic [ADDR_W-1:0] REL_BIAS  = 64'd7;
	localparam logic [ADDR_W-1:0] JMP_BIAS  = 64'd5;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pat_low;
		logic [CFG_DATA_W-1:0] pat_high;
		logic [MASK_W-1:0]     wild_mask;
		logic [LEN_W-1:0]      pat_len;
		logic [MODE_W-1:0]     mode;
		logic [OFF_W-1:0]      disp_off;
		logic [ADDR_W-1:0]     base;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]  pos;
		logic [DISP_W-1:0] disp;
	} q_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/wps_front.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern scanner front end
// Shifts bytes into the window, judges one start position per byte and
// queues every match with its position and raw displacement.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire wps_pkg::cfg_t           cfg,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [7:0]              in_byte,
	input  wire logic                    in_last,
	output logic                         q_valid,
	input  wire logic                    q_ready,
	output wps_pkg::q_item_t             q_item
);
	import wps_pkg::*;

	logic [7:0]           window_q [WINDOW_BYTES];
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_s1;
	logic                 valid_s1;

	logic [LEN_W-1:0]     len;
	logic [NEED_W-1:0]    len_ext;
	logic [NEED_W-1:0]    off_p4;
	logic [NEED_W-1:0]    need;
	logic [8*MAX_PATTERN-1:0] pat_all;
	logic [7:0]           pat_b [MAX_PATTERN];
	logic [WINDOW_BYTES-1:0] hit;
	logic [NEED_W-1:0]    jj;
	logic [NEED_W-1:0]    di;
	logic [DISP_W-1:0]    disp;
	logic                 match;
	logic                 advance;
	logic                 accept;

	always_comb begin
		if (cfg.pat_len == '0)
			len = LEN_W'(1);
		else if (cfg.pat_len > LEN_W'(MAX_PATTERN))
			len = LEN_W'(MAX_PATTERN);
		else
			len = cfg.pat_len;
		len_ext = NEED_W'(len);
		off_p4  = NEED_W'(cfg.disp_off) + DISP_BIAS;
		if (cfg.mode != MODE_PLAIN && off_p4 > len_ext)
			need = off_p4;
		else
			need = len_ext;
	end

	assign pat_all = {cfg.pat_high, cfg.pat_low};

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++)
			pat_b[k] = pat_all[8*k +: 8];
	end

	always_comb begin
		jj = '0;
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			hit[i] = 1'b1;
			if (NEED_W'(i) < need) begin
				jj = need - NEED_W'(i) - NEED_W'(1);
				if (jj < len_ext && !cfg.wild_mask[jj[PAT_IDX_W-1:0]])
					hit[i] = (window_q[i] == pat_b[jj[PAT_IDX_W-1:0]]);
			end
		end
	end

	always_comb begin
		di = '0;
		for (int j = 0; j < DISP_BYTES; j++) begin
			di = need - NEED_W'(cfg.disp_off) - NEED_W'(j) - NEED_W'(1);
			disp[8*j +: 8] = window_q[di[WIN_IDX_W-1:0]];
		end
	end

	assign match = valid_s1 && (need <= NEED_W'(WINDOW_BYTES))
		&& (cnt_s1 >= CNT_W'(need)) && (&hit);

	assign advance  = !valid_s1 || !match || q_ready;
	assign in_ready = advance;
	assign accept   = in_valid && in_ready;

	assign q_valid     = match;
	assign q_item.pos  = cnt_s1 - CNT_W'(need);
	assign q_item.disp = disp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance)
				valid_s1 <= in_valid;
			if (accept)
				cnt_q <= in_last ? '0 : cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_s1      <= cnt_q + CNT_W'(1);
			window_q[0] <= in_byte;
			for (int i = 1; i < WINDOW_BYTES; i++)
				window_q[i] <= window_q[i-1];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/wps_queue.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern scanner match queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire wps_pkg::q_item_t wr_item,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output wps_pkg::q_item_t      rd_item
);
	import wps_pkg::*;

	q_item_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_CW-1:0]  count_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QUEUE_AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QUEUE_AW'(1);
			if (push && !pop)
				count_q <= count_q + QUEUE_CW'(1);
			else if (pop && !push)
				count_q <= count_q - QUEUE_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

`default_nettype wire

// ----- rtl/core/wps_back.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern scanner back end
// Turns a queued match into its start address and resolved address and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire wps_pkg::cfg_t    cfg,
	input  wire logic             q_valid,
	output logic                  q_ready,
	input  wire wps_pkg::q_item_t q_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [wps_pkg::ADDR_W-1:0] out_start,
	output logic [wps_pkg::ADDR_W-1:0] out_resolved
);
	import wps_pkg::*;

	logic                 valid_s1;
	logic [ADDR_W-1:0]    start_s1;
	logic [ADDR_W-1:0]    addend_s1;
	logic                 valid_s2;
	logic [ADDR_W-1:0]    start_s2;
	logic [ADDR_W-1:0]    res_s2;
	logic                 ready_s2;
	logic                 ready_s1;
	logic [ADDR_W-1:0]    disp_ext;
	logic [ADDR_W-1:0]    off_ext;
	logic [ADDR_W-1:0]    addend;

	assign disp_ext = {{(ADDR_W-DISP_W){q_item.disp[DISP_W-1]}}, q_item.disp};
	assign off_ext  = ADDR_W'(cfg.disp_off);

	always_comb begin
		unique case (cfg.mode)
			MODE_PLAIN: addend = off_ext;
			MODE_ABS:   addend = disp_ext + off_ext + ADDR_W'(DISP_BIAS);
			MODE_REL7:  addend = disp_ext + REL_BIAS;
			MODE_JMP5:  addend = disp_ext + JMP_BIAS;
			default:    addend = off_ext;
		endcase
	end

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign q_ready  = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= q_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && q_valid) begin
			start_s1  <= cfg.base + ADDR_W'(q_item.pos);
			addend_s1 <= addend;
		end
		if (ready_s2 && valid_s1) begin
			start_s2 <= start_s1;
			res_s2   <= start_s1 + addend_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign out_start    = start_s2;
	assign out_resolved = res_s2;

endmodule

`default_nettype wire

// ----- rtl/core/wildcard_pattern_scanner_core.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern scanner core
// Scans a byte stream for a wildcard pattern and reports match addresses.
// ----------------------------------------------------------------------------
// The core takes one byte per clock cycle unless the input stalls and judges
// one start position for each byte against a 32-byte window, all pattern
// bytes being compared in parallel. A match passes from the window through
// the queue and the back-end registers to the output; a two-word queue and
// an output register let the input keep streaming while results wait to be
// taken, and the input stalls only when the queue is full and another match
// is pending. There is no clearing pass after reset.
`default_nettype none

module wildcard_pattern_scanner_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [wps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [wps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,  // data_byte
	input  wire logic                            s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [2*wps_pkg::ADDR_W-1:0]         m_axis_tdata   // match_start, resolved_address
);
	import wps_pkg::*;

	cfg_t    cfg_q;
	logic    q_wr_valid;
	logic    q_wr_ready;
	q_item_t q_wr_item;
	logic    q_rd_valid;
	logic    q_rd_ready;
	q_item_t q_rd_item;
	logic [ADDR_W-1:0] out_start;
	logic [ADDR_W-1:0] out_resolved;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pat_low   <= '0;
			cfg_q.pat_high  <= '0;
			cfg_q.wild_mask <= '0;
			cfg_q.pat_len   <= LEN_W'(1);
			cfg_q.mode      <= MODE_PLAIN;
			cfg_q.disp_off  <= '0;
			cfg_q.base      <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PAT_LOW:  cfg_q.pat_low   <= cfg_data;
				REG_PAT_HIGH: cfg_q.pat_high  <= cfg_data;
				REG_WILD:     cfg_q.wild_mask <= cfg_data[MASK_W-1:0];
				REG_LEN:      cfg_q.pat_len   <= cfg_data[LEN_W-1:0];
				REG_MODE:     cfg_q.mode      <= cfg_data[MODE_W-1:0];
				REG_OFF:      cfg_q.disp_off  <= cfg_data[OFF_W-1:0];
				REG_BASE:     cfg_q.base      <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_valid  (q_wr_valid),
		.q_ready  (q_wr_ready),
		.q_item   (q_wr_item)
	);

	wps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_item  (q_wr_item),
		.rd_valid (q_rd_valid),
		.rd_ready (q_rd_ready),
		.rd_item  (q_rd_item)
	);

	wps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_rd_valid),
		.q_ready      (q_rd_ready),
		.q_item       (q_rd_item),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_start    (out_start),
		.out_resolved (out_resolved)
	);

	assign m_axis_tdata = {out_resolved, out_start};

endmodule

`default_nettype wire

// ----- rtl/core/wps_checker.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern scanner checker
// Port-level checks on the scanner core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wildcard_pattern_scanner_core_macros.svh"

module wps_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [wps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [wps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            s_axis_tvalid,
	input  wire logic                            s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,
	input  wire logic                            s_axis_tlast,
	input  wire logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	input  wire logic [2*wps_pkg::ADDR_W-1:0]    m_axis_tdata
);
	import wps_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic [OFF_W-1:0]  off_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] start_rel;
	logic [ADDR_W-1:0] plain_res;
	logic              in_seen_q;
	logic              in_fire;

	assign in_fire   = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
		&& (s_axis_tlast == s_axis_tlast);
	assign start_rel = m_axis_tdata[ADDR_W-1:0] - base_q;
	assign plain_res = m_axis_tdata[ADDR_W-1:0] + ADDR_W'(off_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			off_q     <= '0;
			base_q    <= '0;
			in_seen_q <= 1'b0;
		end else begin
			if (in_fire)
				in_seen_q <= 1'b1;
			if (cfg_wr_en && cfg_index == REG_MODE)
				mode_q <= cfg_data[MODE_W-1:0];
			if (cfg_wr_en && cfg_index == REG_OFF)
				off_q <= cfg_data[OFF_W-1:0];
			if (cfg_wr_en && cfg_index == REG_BASE)
				base_q <= cfg_data;
		end
	end

	// A stalled result word stays on the bus unchanged.
	`WPS_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// No result is shown before any byte has been taken.
	`WPS_ASSERT_IMP(a_no_result_unprompted, clk, arst_n, !in_seen_q, !m_axis_tvalid)

	// In plain mode the resolved address is the start plus the offset.
	`WPS_ASSERT_IMP(a_plain_resolve, clk, arst_n, m_axis_tvalid && mode_q == MODE_PLAIN, m_axis_tdata[2*ADDR_W-1:ADDR_W] == plain_res)

	// A start address lies within the position range of the counter above the base.
	`WPS_ASSERT_IMP(a_start_in_range, clk, arst_n, m_axis_tvalid, start_rel[ADDR_W-1:CNT_W] == '0)

endmodule

bind wildcard_pattern_scanner_core wps_checker u_wps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_wr_en     (cfg_wr_en),
	.cfg_index     (cfg_index),
	.cfg_data      (cfg_data),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
